// ===== hdl/isd_pkg.sv =====
// isd_pkg: shared types, character codes and calendar table for the timestamp converter
// used by isd_ctrl, isd_dp and iso8601_to_serial_date; no dependencies
`default_nettype none

package isd_pkg;

   localparam int unsigned CHAR_W       = 8;
   localparam int unsigned SERIAL_W     = 50;
   localparam int unsigned CALC_CNT_W   = 3;
   localparam logic [CALC_CNT_W-1:0] CALC_LAST = 3'd4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_Z     = 8'h5a;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   typedef struct packed {
      logic step;
      logic load;
   } isd_cmd_type;

   typedef struct packed {
      logic emit;
   } isd_status_type;

   // days before the first of a month, month 1..12
   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/isd_ctrl.sv =====
// isd_ctrl: handshake and sequencing state machine of the timestamp converter
// depends on isd_pkg; drives isd_dp through isd_cmd_type
`default_nettype none

module isd_ctrl
   import isd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   input  wire isd_status_type status,
   output      isd_cmd_type    cmd
);

   typedef enum logic {
      ST_READY,
      ST_CALC
   } state_type;

   state_type             state_ff, state_in;
   logic [CALC_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  load;

   assign req_ready = (state_ff == ST_READY);
   assign rsp_valid = rsp_valid_ff;
   assign load      = (state_ff == ST_CALC) && (cnt_ff == CALC_LAST)
                      && (!rsp_valid_ff || rsp_ready);

   assign cmd.step = req_valid && req_ready;
   assign cmd.load = load;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      case (state_ff)
         ST_READY: begin
            cnt_in = '0;
            if (cmd.step && status.emit) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (load) begin
               state_in = ST_READY;
            end else if (cnt_ff != CALC_LAST) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/isd_dp.sv =====
// isd_dp: character parser, token snapshot and staged date arithmetic
// depends on isd_pkg; sequenced by isd_ctrl
`default_nettype none

module isd_dp
   import isd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire isd_cmd_type                cmd,
   input  wire logic [CHAR_W-1:0]          req_char_code,
   input  wire logic                       req_end_of_text,
   output      isd_status_type             status,
   output      logic signed [SERIAL_W-1:0] rsp_serial_ms,
   output      logic                       rsp_is_last_date
);

   typedef enum logic [2:0] {
      PH_BETWEEN,
      PH_FIXED,
      PH_SECONDS,
      PH_FRACTION,
      PH_ZONE_H,
      PH_ZONE_M,
      PH_DONE
   } phase_type;

   function automatic logic [13:0] push_year(input logic [13:0] acc, input logic [3:0] dig);
      logic [17:0] v;
      v = {4'b0, acc} * 18'd10 + {14'b0, dig};
      return (v > 18'd9999) ? 14'd9999 : v[13:0];
   endfunction

   function automatic logic [6:0] push_small(input logic [6:0] acc, input logic [3:0] dig,
                                             input logic [6:0] limit);
      logic [10:0] v;
      v = {4'b0, acc} * 11'd10 + {7'b0, dig};
      return (v > {4'b0, limit}) ? limit : v[6:0];
   endfunction

   // parser state
   logic [5:0] pos_ff, pos_in, n_pos;
   phase_type  phase_ff, phase_in, n_phase;
   logic [13:0] year_ff, year_in, n_year;
   logic [6:0] month_ff, month_in, n_month;
   logic [6:0] day_ff, day_in, n_day;
   logic [6:0] hour_ff, hour_in, n_hour;
   logic [6:0] minute_ff, minute_in, n_minute;
   logic [6:0] second_ff, second_in, n_second;
   logic [9:0] millis_ff, millis_in, n_millis;
   logic [1:0] fdig_ff, fdig_in, n_fdig;
   logic       zneg_ff, zneg_in, n_zneg;
   logic [6:0] zh_ff, zh_in, n_zh;
   logic [6:0] zm_ff, zm_in, n_zm;
   logic       stop_ff, stop_in, n_stop;

   logic       delim, is_dig, ends, capture;
   logic [3:0] dig;
   logic [6:0] wgt;
   logic       zmin;
   logic       fld_any, fld_year, fld_month, fld_day, fld_hour, fld_minute;

   // token snapshot
   logic [13:0] sn_year_ff;
   logic [6:0]  sn_month_ff, sn_day_ff, sn_hour_ff, sn_minute_ff, sn_second_ff;
   logic [9:0]  sn_millis_ff;
   logic        sn_zneg_ff, sn_last_ff;
   logic [6:0]  sn_zh_ff, sn_zm_ff;

   // stage a: month normalization and time products
   logic [6:0]  mm1;
   logic [12:0] qm_prod, qm1_prod;
   logic [3:0]  qm, qm1;
   logic [6:0]  rem12;
   logic [13:0] a_year_in, a_year_ff;
   logic [3:0]  a_month_in, a_month_ff;
   logic [28:0] a_ta_ff, a_z_ff;
   logic [16:0] a_tb_ff;

   // stage b: year over 100 and signed time of day
   logic [25:0]        qy_prod;
   logic [6:0]         b_q_ff;
   logic signed [30:0] b_ms_in, b_ms_ff;

   // stage c: day count
   logic [13:0]        r100;
   logic               nz4, nz100, nz400, leap;
   logic [21:0]        c_days_in, c_days_ff;
   logic signed [30:0] c_ms_ff;

   // stage d: days to milliseconds
   logic [48:0]        d_prod_ff;
   logic signed [30:0] d_ms_ff;

   logic signed [SERIAL_W-1:0] rsp_serial_ms_ff;
   logic                       rsp_is_last_date_ff;

   assign delim = (req_char_code == CHAR_SPACE) || (req_char_code == CHAR_TAB)
                  || (req_char_code == CHAR_LF) || (req_char_code == CHAR_COMMA)
                  || (req_char_code == CHAR_SEMI);
   assign is_dig = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign dig    = 4'(req_char_code - CHAR_ZERO);
   assign ends   = delim || req_end_of_text;

   assign status.emit = (delim && (phase_ff != PH_BETWEEN)) || (!delim && req_end_of_text);
   assign capture     = cmd.step && status.emit;

   always_comb begin
      case (fdig_ff)
         2'd0:    wgt = 7'd100;
         2'd1:    wgt = 7'd10;
         default: wgt = 7'd1;
      endcase
   end

   always_comb begin
      n_pos = pos_ff; n_phase = phase_ff; n_year = year_ff; n_month = month_ff;
      n_day = day_ff; n_hour = hour_ff; n_minute = minute_ff; n_second = second_ff;
      n_millis = millis_ff; n_fdig = fdig_ff; n_zneg = zneg_ff; n_zh = zh_ff;
      n_zm = zm_ff; n_stop = stop_ff;
      zmin = 1'b0;
      fld_year = 1'b0; fld_month = 1'b0; fld_day = 1'b0; fld_hour = 1'b0;
      fld_minute = 1'b0; fld_any = 1'b0;
      if (!delim && phase_ff == PH_BETWEEN) begin
         n_pos = '0; n_phase = PH_FIXED; n_year = '0; n_month = '0; n_day = '0;
         n_hour = '0; n_minute = '0; n_second = '0; n_millis = '0; n_fdig = '0;
         n_zneg = 1'b0; n_zh = '0; n_zm = '0; n_stop = 1'b0;
      end
      if (!delim) begin
         case (n_phase)
            PH_FIXED: begin
               if (n_pos == 6'd0 || n_pos == 6'd5 || n_pos == 6'd8 || n_pos == 6'd11
                   || n_pos == 6'd14) begin
                  n_stop = 1'b0;
               end
               fld_year   = (n_pos <= 6'd3);
               fld_month  = (n_pos == 6'd5) || (n_pos == 6'd6);
               fld_day    = (n_pos == 6'd8) || (n_pos == 6'd9);
               fld_hour   = (n_pos == 6'd11) || (n_pos == 6'd12);
               fld_minute = (n_pos == 6'd14) || (n_pos == 6'd15);
               fld_any    = fld_year || fld_month || fld_day || fld_hour || fld_minute;
               if (fld_any && !n_stop) begin
                  if (!is_dig) begin
                     n_stop = 1'b1;
                  end else if (fld_year) begin
                     n_year = push_year(n_year, dig);
                  end else if (fld_month) begin
                     n_month = push_small(n_month, dig, 7'd99);
                  end else if (fld_day) begin
                     n_day = push_small(n_day, dig, 7'd99);
                  end else if (fld_hour) begin
                     n_hour = push_small(n_hour, dig, 7'd99);
                  end else begin
                     n_minute = push_small(n_minute, dig, 7'd99);
                  end
               end
               n_pos = n_pos + 1'b1;
               if (n_pos >= 6'd17) begin
                  n_phase = PH_SECONDS;
                  n_stop  = 1'b0;
               end
            end
            PH_SECONDS, PH_FRACTION: begin
               if (req_char_code == CHAR_Z) begin
                  n_phase = PH_DONE;
               end else if (req_char_code == CHAR_PLUS || req_char_code == CHAR_MINUS) begin
                  n_zneg  = (req_char_code == CHAR_MINUS);
                  n_phase = PH_ZONE_H;
                  n_pos   = '0;
                  n_stop  = 1'b0;
               end else if (n_phase == PH_SECONDS) begin
                  if (req_char_code == CHAR_DOT && !n_stop) begin
                     n_phase = PH_FRACTION;
                  end else if (!n_stop) begin
                     if (is_dig) begin
                        n_second = push_small(n_second, dig, 7'd127);
                     end else begin
                        n_stop = 1'b1;
                     end
                  end
               end else if (!n_stop) begin
                  if (!is_dig) begin
                     n_stop = 1'b1;
                  end else if (n_fdig != 2'd3) begin
                     n_millis = n_millis + ({6'b0, dig} * {3'b0, wgt});
                     n_fdig   = n_fdig + 1'b1;
                  end
               end
            end
            PH_ZONE_H: begin
               if (n_pos < 6'd2) begin
                  if (!n_stop) begin
                     if (is_dig) begin
                        n_zh = push_small(n_zh, dig, 7'd99);
                     end else begin
                        n_stop = 1'b1;
                     end
                  end
                  n_pos = n_pos + 1'b1;
               end else begin
                  n_phase = PH_ZONE_M;
                  n_pos   = '0;
                  n_stop  = 1'b0;
                  zmin    = (req_char_code != CHAR_COLON);
               end
            end
            PH_ZONE_M: begin
               zmin = 1'b1;
            end
            default: begin
            end
         endcase
         if (zmin) begin
            if (!n_stop) begin
               if (is_dig) begin
                  n_zm = push_small(n_zm, dig, 7'd99);
               end else begin
                  n_stop = 1'b1;
               end
            end
            n_pos = n_pos + 1'b1;
            if (n_pos >= 6'd2) begin
               n_phase = PH_DONE;
            end
         end
      end
   end

   always_comb begin
      pos_in = pos_ff; phase_in = phase_ff; year_in = year_ff; month_in = month_ff;
      day_in = day_ff; hour_in = hour_ff; minute_in = minute_ff; second_in = second_ff;
      millis_in = millis_ff; fdig_in = fdig_ff; zneg_in = zneg_ff; zh_in = zh_ff;
      zm_in = zm_ff; stop_in = stop_ff;
      if (cmd.step) begin
         if (ends) begin
            pos_in = '0; phase_in = PH_BETWEEN; year_in = '0; month_in = '0; day_in = '0;
            hour_in = '0; minute_in = '0; second_in = '0; millis_in = '0; fdig_in = '0;
            zneg_in = 1'b0; zh_in = '0; zm_in = '0; stop_in = 1'b0;
         end else begin
            pos_in = n_pos; phase_in = n_phase; year_in = n_year; month_in = n_month;
            day_in = n_day; hour_in = n_hour; minute_in = n_minute; second_in = n_second;
            millis_in = n_millis; fdig_in = n_fdig; zneg_in = n_zneg; zh_in = n_zh;
            zm_in = n_zm; stop_in = n_stop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; phase_ff <= PH_BETWEEN; year_ff <= '0; month_ff <= '0;
         day_ff <= '0; hour_ff <= '0; minute_ff <= '0; second_ff <= '0;
         millis_ff <= '0; fdig_ff <= '0; zneg_ff <= 1'b0; zh_ff <= '0;
         zm_ff <= '0; stop_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; phase_ff <= phase_in; year_ff <= year_in; month_ff <= month_in;
         day_ff <= day_in; hour_ff <= hour_in; minute_ff <= minute_in;
         second_ff <= second_in; millis_ff <= millis_in; fdig_ff <= fdig_in;
         zneg_ff <= zneg_in; zh_ff <= zh_in; zm_ff <= zm_in; stop_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         sn_year_ff   <= n_year;
         sn_month_ff  <= n_month;
         sn_day_ff    <= n_day;
         sn_hour_ff   <= n_hour;
         sn_minute_ff <= n_minute;
         sn_second_ff <= n_second;
         sn_millis_ff <= n_millis;
         sn_zneg_ff   <= n_zneg;
         sn_zh_ff     <= n_zh;
         sn_zm_ff     <= n_zm;
         sn_last_ff   <= req_end_of_text;
      end
   end

   // month wrap: x/12 as (x*43)>>9, exact for x below 100
   assign mm1      = sn_month_ff - 7'd1;
   assign qm_prod  = {6'b0, sn_month_ff} * 13'd43;
   assign qm1_prod = {6'b0, mm1} * 13'd43;
   assign qm       = qm_prod[12:9];
   assign qm1      = qm1_prod[12:9];
   assign rem12    = mm1 - {3'b0, qm1} * 7'd12;

   always_comb begin
      a_year_in  = sn_year_ff;
      a_month_in = sn_month_ff[3:0];
      if (sn_month_ff == 7'd0) begin
         a_month_in = 4'd1;
      end else if (sn_month_ff > 7'd12) begin
         a_year_in  = sn_year_ff + {10'b0, qm};
         a_month_in = rem12[3:0] + 4'd1;
      end
   end

   // year/100 as (y*5243)>>19, exact for y below 43699
   assign qy_prod = {12'b0, a_year_ff} * 26'd5243;
   assign b_ms_in = sn_zneg_ff
                    ? $signed({2'b0, a_ta_ff}) + $signed({14'b0, a_tb_ff})
                      + $signed({2'b0, a_z_ff})
                    : $signed({2'b0, a_ta_ff}) + $signed({14'b0, a_tb_ff})
                      - $signed({2'b0, a_z_ff});

   assign r100  = a_year_ff - {7'b0, b_q_ff} * 14'd100;
   assign nz4   = (a_year_ff[1:0] != 2'd0);
   assign nz100 = (r100 != 14'd0);
   assign nz400 = nz100 || (b_q_ff[1:0] != 2'd0);
   assign leap  = (!nz4 && nz100) || !nz400;
   assign c_days_in = 22'(a_year_ff) * 22'd365
                      + 22'(a_year_ff[13:2]) + 22'(nz4)
                      - 22'(b_q_ff) - 22'(nz100)
                      + 22'(b_q_ff[6:2]) + 22'(nz400)
                      + 22'(days_before(a_month_ff)) + 22'(sn_day_ff)
                      + 22'(leap && (a_month_ff > 4'd2));

   always_ff @(posedge clock) begin
      a_year_ff  <= a_year_in;
      a_month_ff <= a_month_in;
      a_ta_ff    <= 29'(sn_hour_ff) * 29'd3600000 + 29'(sn_minute_ff) * 29'd60000;
      a_tb_ff    <= 17'(sn_second_ff) * 17'd1000 + 17'(sn_millis_ff);
      a_z_ff     <= 29'(sn_zh_ff) * 29'd3600000 + 29'(sn_zm_ff) * 29'd60000;
      b_q_ff     <= qy_prod[25:19];
      b_ms_ff    <= b_ms_in;
      c_days_ff  <= c_days_in;
      c_ms_ff    <= b_ms_ff;
      d_prod_ff  <= 49'(c_days_ff) * 49'd86400000;
      d_ms_ff    <= c_ms_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_serial_ms_ff    <= $signed({1'b0, d_prod_ff}) + SERIAL_W'(d_ms_ff);
         rsp_is_last_date_ff <= sn_last_ff;
      end
   end

   assign rsp_serial_ms    = rsp_serial_ms_ff;
   assign rsp_is_last_date = rsp_is_last_date_ff;

endmodule

`default_nettype wire

// ===== hdl/iso8601_to_serial_date.sv =====
// iso8601_to_serial_date: top level of the ISO 8601 timestamp to serial date converter
// depends on isd_pkg, isd_ctrl and isd_dp
//
// Reads text one character per transaction and gives, for every whitespace, comma or
// semicolon separated ISO 8601 timestamp, its serial date in milliseconds since year
// zero in GMT (zone offset subtracted). A character that does not end a timestamp is
// taken without a stall. A character that ends one (a delimiter after a timestamp, or a
// final character flagged end_of_text) holds req_ready low while the date unit runs its
// sequence of month wrap, reciprocal divide by 100, day count and days-to-milliseconds
// multiply, and longer if the previous result has not yet been taken. The result sits
// in an output register until the consumer takes it.
`default_nettype none

module iso8601_to_serial_date
   import isd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [CHAR_W-1:0]          req_char_code,
   input  wire logic                       req_end_of_text,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic signed [SERIAL_W-1:0] rsp_serial_ms,
   output      logic                       rsp_is_last_date
);

   isd_cmd_type    cmd;
   isd_status_type status;

   isd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   isd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_char_code    (req_char_code),
      .req_end_of_text  (req_end_of_text),
      .status           (status),
      .rsp_serial_ms    (rsp_serial_ms),
      .rsp_is_last_date (rsp_is_last_date)
   );

endmodule

`default_nettype wire
